// ===== rtl/wcv_pkg.sv =====
// Package: shared constants, vote type and a label helper for the windowed classifier vote.
`default_nettype none
package wcv_pkg;

   // Window of frame votes
   localparam int WIN_LEN  = 40;
   localparam int WIN_AW   = $clog2(WIN_LEN);

   // Label histogram
   localparam int MAX_CLASSES = 63;
   localparam int HIST_DEPTH  = MAX_CLASSES + 1;
   localparam int HIST_AW     = $clog2(HIST_DEPTH);

   // Field widths
   localparam int LBL_W = 7;
   localparam int WT_W  = 2;
   localparam int CNT_W = 10;
   localparam int CC_W  = 6;

   // Weights and thresholds
   localparam logic [WT_W-1:0]  WT_STRONG   = WT_W'(3);
   localparam logic [WT_W-1:0]  WT_PAIR     = WT_W'(1);
   localparam logic [CNT_W-1:0] DEC_THRESH  = CNT_W'(2 * WIN_LEN);
   localparam logic [CC_W-1:0]  CC_RESET    = CC_W'(32);
   localparam logic [LBL_W-1:0] LBL_UNKNOWN = '0;
   localparam logic [LBL_W-1:0] LBL_NONE    = '1;

   typedef struct packed {
      logic [LBL_W-1:0] label;
      logic [WT_W-1:0]  weight;
   } vote_type;

   // Label maps to a histogram bin
   function automatic logic in_hist(input logic [LBL_W-1:0] lbl);
      in_hist = !lbl[LBL_W-1] && (lbl <= LBL_W'(MAX_CLASSES));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/wcv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wcv_vote.sv =====
// Frame vote former: combines three classifier labels into one weighted vote.
`default_nettype none
module wcv_vote (
   input  wire logic [wcv_pkg::LBL_W-1:0] label_a,
   input  wire logic [wcv_pkg::LBL_W-1:0] label_b,
   input  wire logic [wcv_pkg::LBL_W-1:0] label_c,
   output wcv_pkg::vote_type              vote
);
   import wcv_pkg::*;

   logic ab, ac, bc;

   assign ab = (label_a == label_b);
   assign ac = (label_a == label_c);
   assign bc = (label_b == label_c);

   // Unanimous, pair, or no agreement
   always_comb begin
      if (ab && bc) begin
         vote.label  = label_a;
         vote.weight = WT_STRONG;
      end else if (ab || ac) begin
         vote.label  = label_a;
         vote.weight = WT_PAIR;
      end else if (bc) begin
         vote.label  = label_b;
         vote.weight = WT_PAIR;
      end else begin
         vote.label  = LBL_UNKNOWN;
         vote.weight = WT_STRONG;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/windowed_classifier_vote.sv =====
// The argmax scan compares histogram bins 0 to limit, with limit = class_count. No new item
// is taken until the result is loaded; the scan reads one histogram bin per cycle through
// the single histogram RAM read port, and the block is busy meanwhile.
// Reset (synchronous, active high): window and histogram valid bits clear at once, so
// the window reads as label all ones (LBL_NONE) weight 0 and every bin as zero; class_count returns to 32.
`default_nettype none
module windowed_classifier_vote (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Input items
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [wcv_pkg::LBL_W-1:0]   req_eigen_label,
   input  wire logic [wcv_pkg::LBL_W-1:0]   req_fisher_label,
   input  wire logic [wcv_pkg::LBL_W-1:0]   req_lbph_label,
   // Result items
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [wcv_pkg::LBL_W-1:0]   rsp_frame_label,
   output logic      [wcv_pkg::WT_W-1:0]    rsp_frame_weight,
   output logic      [wcv_pkg::CC_W-1:0]    rsp_decision,
   output logic      [wcv_pkg::CNT_W-1:0]   rsp_best_weight,
   // Configuration
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [wcv_pkg::CC_W-1:0]    csr_data
);
   import wcv_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WIN  = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_RNEW = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_SCAN = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam int WIN_DW = LBL_W + WT_W;

   logic [2:0]          state_ff, state_in;
   logic [CC_W-1:0]     cc_ff;
   logic [WIN_AW-1:0]   ptr_ff, ptr_in;
   logic [WIN_LEN-1:0]  wvld_ff, wvld_in;
   logic [HIST_DEPTH-1:0] hvld_ff, hvld_in;
   vote_type            new_ff, new_in, old_ff, old_in, vote;
   logic                hrvld_ff;
   logic [HIST_AW-1:0]  scan_addr_ff, scan_addr_in;
   logic                scan_issued_ff, scan_issued_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [HIST_AW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]    best_ff, best_in;
   logic [HIST_AW-1:0]  best_idx_ff, best_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   vote_type            rsp_vote_ff, rsp_vote_in;
   logic [CC_W-1:0]     rsp_dec_ff, rsp_dec_in;
   logic [CNT_W-1:0]    rsp_best_ff, rsp_best_in;

   logic                req_take, load_rsp;
   logic                win_rd_en, win_wr_en;
   logic [WIN_DW-1:0]   win_q;
   vote_type            win_old;
   logic                hist_rd_en, hist_wr_en;
   logic [HIST_AW-1:0]  hist_rd_addr, hist_wr_addr;
   logic [CNT_W-1:0]    hist_wr_data, hist_q, hist_val;
   logic [CNT_W-1:0]    old_wt_ext, new_wt_ext;
   logic [HIST_AW-1:0]  limit;

   // Frame vote
   wcv_vote u_vote (
      .label_a (req_eigen_label),
      .label_b (req_fisher_label),
      .label_c (req_lbph_label),
      .vote    (vote)
   );

   // Window of past votes
   wcv_ram #(.WIDTH(WIN_DW), .DEPTH(WIN_LEN)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (new_ff),
      .rd_en   (win_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (win_q)
   );

   // Weight histogram per label
   wcv_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_q)
   );

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_label  = rsp_vote_ff.label;
   assign rsp_frame_weight = rsp_vote_ff.weight;
   assign rsp_decision     = rsp_dec_ff;
   assign rsp_best_weight  = rsp_best_ff;

   // Unwritten slots and bins read as their reset values
   assign win_old    = wvld_ff[ptr_ff] ? vote_type'(win_q) : vote_type'({LBL_NONE, WT_W'(0)});
   assign hist_val   = hrvld_ff ? hist_q : '0;
   assign old_wt_ext = CNT_W'(old_ff.weight);
   assign new_wt_ext = CNT_W'(new_ff.weight);
   assign limit      = HIST_AW'(cc_ff);

   // Sequencer and datapath
   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      wvld_in        = wvld_ff;
      hvld_in        = hvld_ff;
      new_in         = new_ff;
      old_in         = old_ff;
      scan_addr_in   = scan_addr_ff;
      scan_issued_in = scan_issued_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      win_rd_en      = 1'b0;
      win_wr_en      = 1'b0;
      hist_rd_en     = 1'b0;
      hist_rd_addr   = scan_addr_ff;
      hist_wr_en     = 1'b0;
      hist_wr_addr   = old_ff.label[HIST_AW-1:0];
      hist_wr_data   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               new_in    = vote;
               win_rd_en = 1'b1;
               state_in  = ST_WIN;
            end
         end
         ST_WIN: begin
            old_in       = win_old;
            hist_rd_en   = 1'b1;
            hist_rd_addr = win_old.label[HIST_AW-1:0];
            state_in     = ST_SUB;
         end
         ST_SUB: begin
            // Retire the oldest vote, saturating at zero
            if (in_hist(old_ff.label)) begin
               hist_wr_en   = 1'b1;
               hist_wr_addr = old_ff.label[HIST_AW-1:0];
               hist_wr_data = (hist_val >= old_wt_ext) ? hist_val - old_wt_ext : '0;
               hvld_in[old_ff.label[HIST_AW-1:0]] = 1'b1;
            end
            win_wr_en       = 1'b1;
            wvld_in[ptr_ff] = 1'b1;
            ptr_in = (ptr_ff == WIN_AW'(WIN_LEN - 1)) ? '0 : ptr_ff + WIN_AW'(1);
            state_in = ST_RNEW;
         end
         ST_RNEW: begin
            hist_rd_en   = 1'b1;
            hist_rd_addr = new_ff.label[HIST_AW-1:0];
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            if (in_hist(new_ff.label)) begin
               hist_wr_en   = 1'b1;
               hist_wr_addr = new_ff.label[HIST_AW-1:0];
               hist_wr_data = hist_val + new_wt_ext;
               hvld_in[new_ff.label[HIST_AW-1:0]] = 1'b1;
            end
            scan_addr_in   = '0;
            scan_issued_in = 1'b0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            // Issue one bin read per cycle
            if (!scan_issued_ff) begin
               hist_rd_en   = 1'b1;
               hist_rd_addr = scan_addr_ff;
               cmp_vld_in   = 1'b1;
               cmp_idx_in   = scan_addr_ff;
               if (scan_addr_ff == limit) begin
                  scan_issued_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + HIST_AW'(1);
               end
            end
            // Compare the bin read last cycle; strict greater keeps lowest label
            if (cmp_vld_ff) begin
               if (cmp_idx_ff == '0 || hist_val > best_ff) begin
                  best_in     = hist_val;
                  best_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == limit) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vote_in  = rsp_vote_ff;
      rsp_dec_in   = rsp_dec_ff;
      rsp_best_in  = rsp_best_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_vote_in  = new_ff;
         rsp_dec_in   = (best_ff > DEC_THRESH) ? CC_W'(best_idx_ff) : '0;
         rsp_best_in  = best_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cc_ff        <= CC_RESET;
         ptr_ff       <= '0;
         wvld_ff      <= '0;
         hvld_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wvld_ff      <= wvld_in;
         hvld_ff      <= hvld_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cc_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_ff         <= new_in;
      old_ff         <= old_in;
      scan_addr_ff   <= scan_addr_in;
      scan_issued_ff <= scan_issued_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      rsp_vote_ff    <= rsp_vote_in;
      rsp_dec_ff     <= rsp_dec_in;
      rsp_best_ff    <= rsp_best_in;
      if (hist_rd_en) begin
         hrvld_ff <= hvld_ff[hist_rd_addr];
      end
   end

endmodule
`default_nettype wire
